### rtl/dgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal glyph sequencer package
// Shared widths, register codes, the queue entry and configuration types,
// and a constant power-of-ten helper used for clamping.
// ----------------------------------------------------------------------------
package dgs_pkg;

  // Width of the input number and of its magnitude.
  localparam int unsigned MagW      = 32;
  // Decimal digits needed for any 32-bit magnitude.
  localparam int unsigned BcdDigits = 10;
  localparam int unsigned BcdW      = 4 * BcdDigits;
  // Digit index width, enough to address every decimal digit.
  localparam int unsigned IdxW      = 4;
  // Conversion step counter width (one step per magnitude bit).
  localparam int unsigned StepW     = 5;

  localparam int unsigned RegionW   = 12;
  localparam int unsigned WidthW    = 6;
  localparam int unsigned CoordW    = 11;
  localparam int unsigned XW        = 12;
  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned CfgIdxW   = 2;

  // Depth of the queue between the converter and the emitter.
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIGIT_WIDTH  = 2'd0,
    CFG_ZERO_REGION  = 2'd1,
    CFG_MINUS_REGION = 2'd2
  } cfg_idx_e;

  // Live configuration seen by the emitter.
  typedef struct packed {
    logic [WidthW-1:0]  digit_width;
    logic [RegionW-1:0] zero_region;
    logic [RegionW-1:0] minus_region;
  } cfg_t;

  // One converted number waiting to be drawn.
  typedef struct packed {
    logic [BcdW-1:0]          bcd;
    logic [IdxW-1:0]          top_idx;
    logic                     minus;
    logic signed [CoordW-1:0] left_x;
    logic signed [CoordW-1:0] top_y;
  } entry_t;

  // Ten to the power n, evaluated at elaboration.
  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] acc;
    acc = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      acc = acc * 64'd10;
    end
    return acc;
  endfunction

endpackage

### rtl/dgs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal glyph sequencer front end
// Accepts a number, clamps its magnitude by mode, converts it to BCD with a
// bit-serial shift-and-add-three loop and pushes the result into the queue.
// ----------------------------------------------------------------------------
module dgs_front #(
  parameter int unsigned INT_DIGITS   = 10,
  parameter int unsigned SCORE_DIGITS = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic signed [dgs_pkg::MagW-1:0]   number_i,
  input  logic signed [dgs_pkg::CoordW-1:0] left_x_i,
  input  logic signed [dgs_pkg::CoordW-1:0] top_y_i,
  output logic                              push_o,
  input  logic                              full_i,
  output dgs_pkg::entry_t                   entry_o
);
  import dgs_pkg::*;

  localparam logic [63:0]     IntMax    = pow10(INT_DIGITS) - 64'd1;
  localparam logic [63:0]     ScoreMax  = pow10(SCORE_DIGITS) - 64'd1;
  localparam logic [IdxW-1:0] ScoreTop  = IdxW'(SCORE_DIGITS - 1);
  localparam logic [StepW-1:0] LastStep = StepW'(MagW - 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  logic [MagW-1:0]          mag_q, mag_d;
  logic [BcdW-1:0]          bcd_q, bcd_d;
  logic                     mode_q, mode_d;
  logic                     minus_q, minus_d;
  logic signed [CoordW-1:0] x_q, x_d;
  logic signed [CoordW-1:0] y_q, y_d;

  logic            accept;
  logic            neg;
  logic [MagW-1:0] raw;
  logic [MagW-1:0] abs_val;
  logic [MagW-1:0] mag_in;
  logic [BcdW-1:0] bcd_adj;
  logic [IdxW-1:0] top_idx;

  // Only an idle front end takes a new number.
  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Magnitude and clamping for both modes.
  always_comb begin
    raw     = number_i;
    neg     = raw[MagW-1];
    abs_val = neg ? (~raw + MagW'(1)) : raw;
    if (!mode_i) begin
      mag_in = ({32'd0, abs_val} > IntMax) ? IntMax[MagW-1:0] : abs_val;
    end else if (neg) begin
      mag_in = '0;
    end else begin
      mag_in = ({32'd0, raw} > ScoreMax) ? ScoreMax[MagW-1:0] : raw;
    end
  end

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
                                                    : bcd_q[4*i +: 4];
    end
  end

  // Number of digits to print, as the index of the leading digit.
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < BcdDigits; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        top_idx = IdxW'(i);
      end
    end
    if (mode_q) begin
      top_idx = ScoreTop;
    end
  end

  // Control sequencing.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    mode_d  = mode_q;
    minus_d = minus_q;
    x_d     = x_q;
    y_d     = y_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          mag_d   = mag_in;
          bcd_d   = '0;
          mode_d  = mode_i;
          minus_d = !mode_i && neg;
          x_d     = left_x_i;
          y_d     = top_y_i;
          step_d  = '0;
          state_d = F_CONV;
        end
      end
      F_CONV: begin
        bcd_d  = {bcd_adj[BcdW-2:0], mag_q[MagW-1]};
        mag_d  = {mag_q[MagW-2:0], 1'b0};
        step_d = step_q + StepW'(1);
        if (step_q == LastStep) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  assign entry_o.bcd     = bcd_q;
  assign entry_o.top_idx = top_idx;
  assign entry_o.minus   = minus_q;
  assign entry_o.left_x  = x_q;
  assign entry_o.top_y   = y_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    bcd_q   <= bcd_d;
    mode_q  <= mode_d;
    minus_q <= minus_d;
    x_q     <= x_d;
    y_q     <= y_d;
  end

endmodule

### rtl/dgs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal glyph sequencer queue
// Short first-in first-out buffer of converted numbers between the front end
// and the glyph emitter.
// ----------------------------------------------------------------------------
module dgs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dgs_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output dgs_pkg::entry_t rdata_o,
  output logic            empty_o
);
  import dgs_pkg::*;

  entry_t                slot_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FifoCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### rtl/dgs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal glyph sequencer emitter
// Takes one converted number from the queue and sends its glyphs out one per
// transaction: the minus sign if any, then the digits from the leading one.
// ----------------------------------------------------------------------------
module dgs_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dgs_pkg::cfg_t                      cfg_i,
  input  logic                               empty_i,
  input  dgs_pkg::entry_t                    entry_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [dgs_pkg::RegionW-1:0]        region_id_o,
  output logic signed [dgs_pkg::XW-1:0]      glyph_x_o,
  output logic signed [dgs_pkg::CoordW-1:0]  glyph_y_o,
  output logic                               last_o
);
  import dgs_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } back_state_e;

  back_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  logic [BcdW-1:0]          bcd_q, bcd_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic                     minus_q, minus_d;
  logic [XW-1:0]            x_q, x_d;
  logic signed [CoordW-1:0] y_q, y_d;

  logic [RegionW-1:0]       region_q, region_d;
  logic [XW-1:0]            gx_q, gx_d;
  logic signed [CoordW-1:0] gy_q, gy_d;
  logic                     last_q, last_d;

  logic       out_free;
  logic       emit;
  logic [3:0] digit;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (state_q == B_RUN) && out_free;
  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign digit    = bcd_q[{idx_q, 2'b00} +: 4];

  // Glyph sequencing.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    bcd_d       = bcd_q;
    idx_d       = idx_q;
    minus_d     = minus_q;
    x_d         = x_q;
    y_d         = y_q;
    region_d    = region_q;
    gx_d        = gx_q;
    gy_d        = gy_q;
    last_d      = last_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          bcd_d   = entry_i.bcd;
          idx_d   = entry_i.top_idx;
          minus_d = entry_i.minus;
          x_d     = XW'(entry_i.left_x);
          y_d     = entry_i.top_y;
          state_d = B_RUN;
        end
      end
      B_RUN: begin
        if (emit) begin
          out_valid_d = 1'b1;
          gx_d        = x_q;
          gy_d        = y_q;
          x_d         = x_q + {{(XW-WidthW){1'b0}}, cfg_i.digit_width};
          if (minus_q) begin
            region_d = cfg_i.minus_region;
            last_d   = 1'b0;
            minus_d  = 1'b0;
          end else begin
            region_d = cfg_i.zero_region + {{(RegionW-4){1'b0}}, digit};
            last_d   = (idx_q == '0);
            idx_d    = idx_q - IdxW'(1);
            if (idx_q == '0) begin
              state_d = B_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign region_id_o = region_q;
  assign glyph_x_o   = gx_q;
  assign glyph_y_o   = gy_q;
  assign last_o      = last_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and output registers.
  always_ff @(posedge clk_i) begin
    bcd_q    <= bcd_d;
    idx_q    <= idx_d;
    minus_q  <= minus_d;
    x_q      <= x_d;
    y_q      <= y_d;
    region_q <= region_d;
    gx_q     <= gx_d;
    gy_q     <= gy_d;
    last_q   <= last_d;
  end

endmodule

### rtl/decimal_digit_glyph_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal digit glyph sequencer
// Turns a signed number into a run of glyph draws (region id, x, y, last).
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) takes one number per
//   transaction with its mode and start position. The output channel
//   (out_valid_o / out_stall_i) gives one glyph per transaction; last_o marks
//   the final glyph of a number: an optional minus sign, then the digits.
//   The front end accepts a number, converts it with the bit-serial binary
//   to BCD loop and enters it into the queue; it takes no new number until
//   then. After a fetch from the queue the emitter offers one glyph per cycle
//   while the output does not stall; the conversion loop sets the sustained
//   rate of numbers, and a two-entry queue lets the next conversion overlap.
//   A stall on the output holds the glyph register; the emitter, the queue
//   and the front end fill up behind it and the input stalls.
//   Reset empties the queue and loads the default configuration. Write
//   configuration only while the block is idle.
// ----------------------------------------------------------------------------
module decimal_digit_glyph_sequencer_core #(
  parameter int unsigned INT_DIGITS   = 10,
  parameter int unsigned SCORE_DIGITS = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dgs_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [dgs_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic signed [dgs_pkg::MagW-1:0]     number_i,
  input  logic signed [dgs_pkg::CoordW-1:0]   left_x_i,
  input  logic signed [dgs_pkg::CoordW-1:0]   top_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dgs_pkg::RegionW-1:0]         region_id_o,
  output logic signed [dgs_pkg::XW-1:0]       glyph_x_o,
  output logic signed [dgs_pkg::CoordW-1:0]   glyph_y_o,
  output logic                                last_o
);
  import dgs_pkg::*;

  cfg_t   cfg_q;
  entry_t push_entry;
  entry_t pop_entry;
  logic   push, full, pop, empty;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.digit_width  <= WidthW'(22);
      cfg_q.zero_region  <= RegionW'(11);
      cfg_q.minus_region <= RegionW'(10);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DIGIT_WIDTH:  cfg_q.digit_width  <= cfg_wdata_i[WidthW-1:0];
        CFG_ZERO_REGION:  cfg_q.zero_region  <= cfg_wdata_i[RegionW-1:0];
        CFG_MINUS_REGION: cfg_q.minus_region <= cfg_wdata_i[RegionW-1:0];
        default: begin
        end
      endcase
    end
  end

  dgs_front #(
    .INT_DIGITS   (INT_DIGITS),
    .SCORE_DIGITS (SCORE_DIGITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .number_i   (number_i),
    .left_x_i   (left_x_i),
    .top_y_i    (top_y_i),
    .push_o     (push),
    .full_i     (full),
    .entry_o    (push_entry)
  );

  dgs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_entry),
    .empty_o (empty)
  );

  dgs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .region_id_o (region_id_o),
    .glyph_x_o   (glyph_x_o),
    .glyph_y_o   (glyph_y_o),
    .last_o      (last_o)
  );

endmodule
